// ===== rtl/crp_pkg.sv =====
// Shared types and constants for the A1 cell reference parser.
`default_nettype none

package crp_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned NumW   = 16;
  localparam int unsigned AccW   = NumW + 1;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [AccW-1:0] AccCap = AccW'(1) << NumW;
  localparam logic [NumW-1:0] ColumnLimitRst = 16'd32767;
  localparam logic [NumW-1:0] RowLimitRst    = 16'd32767;

  localparam logic [CharW-1:0] ChrBang   = 8'h21;  // '!'
  localparam logic [CharW-1:0] ChrDollar = 8'h24;  // '$'
  localparam logic [CharW-1:0] ChrZero   = 8'h30;  // '0'
  localparam logic [CharW-1:0] ChrNine   = 8'h39;  // '9'
  localparam logic [CharW-1:0] ChrUpA    = 8'h41;  // 'A'
  localparam logic [CharW-1:0] ChrUpZ    = 8'h5a;  // 'Z'
  localparam logic [CharW-1:0] ChrLoA    = 8'h61;  // 'a'
  localparam logic [CharW-1:0] ChrLoZ    = 8'h7a;  // 'z'

  typedef enum logic [CfgIdxW-1:0] {
    CFG_COLUMN_LIMIT = 1'b0,
    CFG_ROW_LIMIT    = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_START   = 3'd0,
    PH_CDOLLAR = 3'd1,
    PH_LETTERS = 3'd2,
    PH_RDOLLAR = 3'd3,
    PH_DIGITS  = 3'd4,
    PH_ERROR   = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_EMPTY     = 3'd1,
    ERR_BAD_FIRST = 3'd2,
    ERR_NO_ROW    = 3'd3,
    ERR_COL_HIGH  = 3'd4,
    ERR_NON_DIGIT = 3'd5,
    ERR_ROW_HIGH  = 3'd6,
    ERR_ROW_ZERO  = 3'd7
  } err_e;

  typedef struct packed {
    phase_e          phase;
    logic [AccW-1:0] col_acc;
    logic [AccW-1:0] row_acc;
    logic            col_dollar;
    logic            row_dollar;
    logic            bang;
    err_e            err;
  } parse_t;

  localparam parse_t ParseClear = '{
    phase:      PH_START,
    col_acc:    '0,
    row_acc:    '0,
    col_dollar: 1'b0,
    row_dollar: 1'b0,
    bang:       1'b0,
    err:        ERR_NONE
  };

  typedef struct packed {
    logic            ref_valid;
    logic [NumW-1:0] column_number;
    logic [NumW-1:0] row_number;
    logic            column_absolute;
    logic            row_absolute;
    logic            sheet_prefixed;
    err_e            error_kind;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/crp_step.sv =====
// One character step of the parser: next parse state and the result it would give.
`default_nettype none

module crp_step import crp_pkg::*; (
  input  parse_t           cur_i,
  input  logic [CharW-1:0] char_i,
  input  logic [NumW-1:0]  column_limit_i,
  input  logic [NumW-1:0]  row_limit_i,
  output parse_t           nxt_o,
  output result_t          res_o
);

  logic            is_upper, is_lower, is_letter, is_digit;
  logic [4:0]      letter_val;
  logic [3:0]      digit_val;
  logic [21:0]     col_mac;
  logic [20:0]     row_mac;
  logic [AccW-1:0] col_sat, row_sat;
  err_e            err;

  assign is_upper  = (char_i >= ChrUpA) && (char_i <= ChrUpZ);
  assign is_lower  = (char_i >= ChrLoA) && (char_i <= ChrLoZ);
  assign is_letter = is_upper || is_lower;
  assign is_digit  = (char_i >= ChrZero) && (char_i <= ChrNine);
  assign digit_val = char_i[3:0];

  always_comb begin
    letter_val = 5'd0;
    if (is_upper) begin
      letter_val = 5'(char_i - ChrUpA) + 5'd1;
    end else if (is_lower) begin
      letter_val = 5'(char_i - ChrLoA) + 5'd1;
    end
  end

  // column * 26 + letter, row * 10 + digit, both capped
  assign col_mac = 22'(cur_i.col_acc) * 22'd26 + 22'(letter_val);
  assign row_mac = 21'(cur_i.row_acc) * 21'd10 + 21'(digit_val);
  assign col_sat = (col_mac > 22'(AccCap)) ? AccCap : col_mac[AccW-1:0];
  assign row_sat = (row_mac > 21'(AccCap)) ? AccCap : row_mac[AccW-1:0];

  // next state
  always_comb begin
    nxt_o = cur_i;
    if ((char_i == ChrBang) && !cur_i.bang) begin
      nxt_o      = ParseClear;
      nxt_o.bang = 1'b1;
    end else begin
      unique case (cur_i.phase)
        PH_START: begin
          if (char_i == ChrDollar) begin
            nxt_o.col_dollar = 1'b1;
            nxt_o.phase      = PH_CDOLLAR;
          end else if (is_letter) begin
            nxt_o.col_acc = AccW'(letter_val);
            nxt_o.phase   = PH_LETTERS;
          end else begin
            nxt_o.err   = ERR_BAD_FIRST;
            nxt_o.phase = PH_ERROR;
          end
        end
        PH_CDOLLAR: begin
          if (is_letter) begin
            nxt_o.col_acc = AccW'(letter_val);
            nxt_o.phase   = PH_LETTERS;
          end else begin
            nxt_o.err   = ERR_BAD_FIRST;
            nxt_o.phase = PH_ERROR;
          end
        end
        PH_LETTERS: begin
          if (is_letter) begin
            nxt_o.col_acc = col_sat;
          end else if (cur_i.col_acc > AccW'(column_limit_i)) begin
            nxt_o.err   = ERR_COL_HIGH;
            nxt_o.phase = PH_ERROR;
          end else if (char_i == ChrDollar) begin
            nxt_o.row_dollar = 1'b1;
            nxt_o.phase      = PH_RDOLLAR;
          end else if (is_digit) begin
            nxt_o.row_acc = AccW'(digit_val);
            nxt_o.phase   = PH_DIGITS;
          end else begin
            nxt_o.err   = ERR_NON_DIGIT;
            nxt_o.phase = PH_ERROR;
          end
        end
        PH_RDOLLAR: begin
          if (is_digit) begin
            nxt_o.row_acc = AccW'(digit_val);
            nxt_o.phase   = PH_DIGITS;
          end else begin
            nxt_o.err   = ERR_NON_DIGIT;
            nxt_o.phase = PH_ERROR;
          end
        end
        PH_DIGITS: begin
          if (is_digit) begin
            nxt_o.row_acc = row_sat;
          end else begin
            nxt_o.err   = ERR_NON_DIGIT;
            nxt_o.phase = PH_ERROR;
          end
        end
        default: ;  // error phase holds until the last char or a first '!'
      endcase
    end
  end

  // result as seen after this char
  always_comb begin
    unique case (nxt_o.phase) inside
      PH_ERROR:              err = nxt_o.err;
      PH_START, PH_CDOLLAR:  err = ERR_EMPTY;
      PH_LETTERS, PH_RDOLLAR: err = ERR_NO_ROW;
      default: begin
        if (nxt_o.row_acc > AccW'(row_limit_i)) begin
          err = ERR_ROW_HIGH;
        end else if (nxt_o.row_acc == '0) begin
          err = ERR_ROW_ZERO;
        end else begin
          err = ERR_NONE;
        end
      end
    endcase
  end

  always_comb begin
    res_o.ref_valid       = (err == ERR_NONE);
    res_o.column_number   = (err == ERR_NONE) ? nxt_o.col_acc[NumW-1:0] : '0;
    res_o.row_number      = (err == ERR_NONE) ? nxt_o.row_acc[NumW-1:0] : '0;
    res_o.column_absolute = nxt_o.col_dollar;
    res_o.row_absolute    = nxt_o.row_dollar;
    res_o.sheet_prefixed  = nxt_o.bang;
    res_o.error_kind      = err;
  end

endmodule

`default_nettype wire

// ===== rtl/cell_reference_parser.sv =====
// Top level of the A1 cell reference parser: input register, parse state, result register.
`default_nettype none

// A1-style cell reference parser. Characters arrive one item per cycle on the
// input channel while in_ready_o is high, the final one flagged by last_char_i.
// A first '!' discards everything before it and marks the reference as
// sheet-prefixed; the cell part is an optional '$', letters (any case,
// bijective base 26), an optional '$' and decimal row digits. Only the last
// character of a reference yields a result item, carrying column, row, the
// two '$' flags, the sheet flag and an error code (0 ok, 1 empty, 2 bad first
// char, 3 no row, 4 column high, 5 non-digit, 6 row high, 7 row zero); column
// and row read zero on error. Throughput is one character per cycle with no
// gaps between references while the result register is free or being taken.
// A character is held in the input register, then the combinational parse step
// (two constant multiply-adds and compares) updates the parse state and, for a
// last character, loads the result register that drives the output. The input
// side keeps taking items while a result waits, and stalls only once the
// result register is full and the input register holds a pending item. Limits
// are written through the configuration port (index 0 column_limit, index 1
// row_limit), reset to 32767, and should be written only while the block is
// idle; the config port is always ready.

module cell_reference_parser import crp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // character input
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [CharW-1:0]   char_code_i,
  input  logic               last_char_i,
  // result output
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               ref_valid_o,
  output logic [NumW-1:0]    column_number_o,
  output logic [NumW-1:0]    row_number_o,
  output logic               column_absolute_o,
  output logic               row_absolute_o,
  output logic               sheet_prefixed_o,
  output logic [2:0]         error_kind_o,
  // configuration writes
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [NumW-1:0]    cfg_data_i
);

  // limit registers
  logic [NumW-1:0] column_limit_q, row_limit_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_limit_q <= ColumnLimitRst;
      row_limit_q    <= RowLimitRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_COLUMN_LIMIT: column_limit_q <= cfg_data_i;
        CFG_ROW_LIMIT:    row_limit_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  logic             in_valid_q;
  logic [CharW-1:0] char_q;
  logic             last_q;
  logic             advance;  // result register can take a new value
  logic             step;     // registered char goes through the parser

  assign advance    = !out_valid_o || out_ready_i;
  assign step       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      char_q <= char_code_i;
      last_q <= last_char_i;
    end
  end

  // parse state
  parse_t  parse_q, parse_d, parse_nxt;
  result_t res;

  crp_step u_step (
    .cur_i          (parse_q),
    .char_i         (char_q),
    .column_limit_i (column_limit_q),
    .row_limit_i    (row_limit_q),
    .nxt_o          (parse_nxt),
    .res_o          (res)
  );

  // a last char ends the reference; the parser starts clean for the next one
  always_comb begin
    parse_d = parse_q;
    if (step) begin
      parse_d = last_q ? ParseClear : parse_nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parse_q <= ParseClear;
    end else begin
      parse_q <= parse_d;
    end
  end

  // result register
  logic    out_valid_q;
  result_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= step && last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && last_q) begin
      res_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign ref_valid_o       = res_q.ref_valid;
  assign column_number_o   = res_q.column_number;
  assign row_number_o      = res_q.row_number;
  assign column_absolute_o = res_q.column_absolute;
  assign row_absolute_o    = res_q.row_absolute;
  assign sheet_prefixed_o  = res_q.sheet_prefixed;
  assign error_kind_o      = res_q.error_kind;

endmodule

`default_nettype wire
